/* rtl/lcar_pkg.sv */
// Shared constants and types for the load-cell converter reader.
`timescale 1ns / 1ps
package lcar_pkg;
    localparam int TICKS_PER_MS     = 1000;
    localparam int RECOVER_MS       = 1000;
    localparam int READ_TIMEOUT_MS  = 500;
    localparam int POWER_DOWN_TICKS = 80;
    localparam int TARE_GAP_MS      = 10;

    localparam int REC_TICKS = RECOVER_MS * TICKS_PER_MS;
    localparam int TO_TICKS  = READ_TIMEOUT_MS * TICKS_PER_MS;
    localparam int GAP_TICKS = TARE_GAP_MS * TICKS_PER_MS;

    localparam int WT_W = $clog2(REC_TICKS + 2);
    localparam int PT_W = $clog2(TO_TICKS + GAP_TICKS + POWER_DOWN_TICKS + 2);

    localparam int RAW_W   = 24;
    localparam int GAIN_W  = 5;
    localparam int CAL_W   = 24;
    localparam int TS_W    = 8;
    localparam int WGT_W   = 32;
    localparam int SUM_W   = 32;
    localparam int CIDX_W  = 2;
    localparam int NUM_W   = 41;
    localparam int DCNT_W  = 6;

    localparam logic [GAIN_W-1:0] DATA_BITS     = GAIN_W'(24);
    localparam logic [TS_W-1:0]   TARE_DEFAULT  = TS_W'(10);
    localparam logic [GAIN_W-1:0] GAIN_RESET    = GAIN_W'(25);
    localparam logic [CAL_W-1:0]  CAL_RESET     = CAL_W'(110080);

    localparam logic [CIDX_W-1:0] CFG_GAIN  = CIDX_W'(0);
    localparam logic [CIDX_W-1:0] CFG_CAL   = CIDX_W'(1);
    localparam logic [CIDX_W-1:0] CFG_TARE  = CIDX_W'(2);

    typedef enum logic [4:0] {
        PH_IDLE      = 5'b00001,
        PH_READ      = 5'b00010,
        PH_RECOVER   = 5'b00100,
        PH_TARE_WAIT = 5'b01000,
        PH_TARE_GAP  = 5'b10000
    } t_phase;

    typedef enum logic [2:0] {
        CT_READY = 3'b001,
        CT_DIV   = 3'b010,
        CT_OUT   = 3'b100
    } t_ctrl;
endpackage

/* rtl/load_cell_adc_reader.sv */
// Load-cell converter reader: tick-driven serial read, tare and weight scaling.
// A tick request is answered in the cycle after acceptance, or after the 41-step
// bit-serial divider if it ends a weighed read (offset known, calibration nonzero) or a tare.
// A new tick is accepted only after the receiver has taken the previous result.
// Reset (synchronous, active low) returns to idle polling with offset unknown,
// registers at their defaults and raw value and weight zero.
`timescale 1ns / 1ps
module load_cell_adc_reader (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic                          i_command,
    input  logic                          i_dout,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic                          o_sck,
    output logic                          o_sample_valid,
    output logic signed [lcar_pkg::RAW_W-1:0] o_raw_value,
    output logic [lcar_pkg::WGT_W-1:0]    o_weight,
    output logic                          o_tare_busy,
    output logic                          o_tare_done,
    output logic                          o_recovering,
    input  logic                          i_cfg_we,
    input  logic [lcar_pkg::CIDX_W-1:0]   i_cfg_idx,
    input  logic [lcar_pkg::CAL_W-1:0]    i_cfg_data
);
    import lcar_pkg::*;

    t_ctrl               r_ctrl;
    t_phase              r_phase, n_phase;
    logic [GAIN_W-1:0]   r_gain;
    logic [CAL_W-1:0]    r_cal;
    logic [TS_W-1:0]     r_tsamp;
    logic [4:0]          r_bc, n_bc;
    logic [PT_W-1:0]     r_pt, n_pt;
    logic [RAW_W-1:0]    r_shift, n_shift;
    logic [WT_W-1:0]     r_wt, n_wt;
    logic                r_wa, n_wa;
    logic [RAW_W-1:0]    r_off, n_off;
    logic                r_known, n_known;
    logic                r_ta, n_ta;
    logic [SUM_W-1:0]    r_sum, n_sum;
    logic [TS_W-1:0]     r_left, n_left;
    logic [TS_W-1:0]     r_total, n_total;
    logic [RAW_W-1:0]    r_raw, n_raw;
    logic [WGT_W-1:0]    r_wgt, n_wgt;
    logic                r_sck, n_sck;
    logic                r_sv, n_sv;
    logic                r_done, n_done;
    logic                r_rec, n_rec;
    logic                n_div_w, n_div_t;

    logic [CAL_W-1:0]    r_rem;
    logic [NUM_W-1:0]    r_num;
    logic [CAL_W-1:0]    r_den;
    logic [DCNT_W-1:0]   r_dcnt;
    logic                r_dtare, r_dneg;

    logic                w_accept;
    logic [RAW_W:0]      w_delta, w_mag;
    logic [SUM_W-1:0]    w_summag;
    logic [GAIN_W-1:0]   w_total;
    logic [CAL_W:0]      w_trial;
    logic                w_ge;
    logic [NUM_W-1:0]    w_qnext;
    logic [SUM_W-1:0]    w_tq;

    assign o_stall        = (r_ctrl != CT_READY);
    assign w_accept       = (r_ctrl == CT_READY) && i_valid;
    assign o_valid        = (r_ctrl == CT_OUT);
    assign o_sck          = r_sck;
    assign o_sample_valid = r_sv;
    assign o_raw_value    = r_raw;
    assign o_weight       = r_wgt;
    assign o_tare_busy    = r_ta;
    assign o_tare_done    = r_done;
    assign o_recovering   = r_rec;

    assign w_delta  = {r_shift[RAW_W-1], r_shift} - {r_off[RAW_W-1], r_off};
    assign w_mag    = w_delta[RAW_W] ? -w_delta : w_delta;
    assign w_summag = r_sum[SUM_W-1] ? -r_sum : r_sum;
    assign w_total  = (r_gain < DATA_BITS) ? DATA_BITS : r_gain;

    // one restoring-division step per cycle
    assign w_trial = {r_rem, r_num[NUM_W-1]};
    assign w_ge    = (w_trial >= {1'b0, r_den});
    assign w_qnext = {r_num[NUM_W-2:0], w_ge};
    assign w_tq    = r_dneg ? -w_qnext[SUM_W-1:0] : w_qnext[SUM_W-1:0];

    always_comb begin
        n_phase = r_phase;  n_bc = r_bc;   n_pt = r_pt;     n_shift = r_shift;
        n_wt = r_wt;        n_wa = r_wa;   n_off = r_off;   n_known = r_known;
        n_ta = r_ta;        n_sum = r_sum; n_left = r_left; n_total = r_total;
        n_raw = r_raw;      n_wgt = r_wgt;
        n_sck = 1'b0; n_sv = 1'b0; n_done = 1'b0; n_rec = 1'b0;
        n_div_w = 1'b0; n_div_t = 1'b0;
        unique case (r_phase)
            PH_IDLE: begin
                if (i_command) begin
                    n_total = (r_tsamp != '0) ? r_tsamp : TARE_DEFAULT;
                    n_left  = n_total;
                    n_sum   = '0;
                    n_ta    = 1'b1;
                    n_phase = PH_TARE_WAIT;
                    n_pt    = '0;
                end else if (i_dout) begin
                    if (!r_wa) begin
                        n_wa = 1'b1;
                        n_wt = '0;
                    end else begin
                        if (r_wt < WT_W'(REC_TICKS)) n_wt = r_wt + 1'b1;
                        if (n_wt >= WT_W'(REC_TICKS)) begin
                            n_phase = PH_RECOVER;
                            n_pt    = '0;
                            n_wt    = '0;
                        end
                    end
                end else begin
                    n_wa = 1'b0;
                    n_wt = '0;
                    n_phase = PH_READ;
                    n_bc = '0;
                    n_pt = '0;
                    n_shift = '0;
                end
            end
            PH_READ: begin
                if (r_pt == '0) begin
                    n_sck = 1'b1;
                    if (r_bc < DATA_BITS) n_shift = {r_shift[RAW_W-2:0], i_dout};
                    n_pt = PT_W'(1);
                end else if ({1'b0, r_bc} + 6'd1 >= {1'b0, w_total}) begin
                    // read complete
                    n_raw = r_shift;
                    if (r_ta) begin
                        n_sum = r_sum + {{(SUM_W-RAW_W){r_shift[RAW_W-1]}}, r_shift};
                        if (r_left != '0) n_left = r_left - 1'b1;
                        n_phase = PH_TARE_GAP;
                        n_pt = '0;
                    end else begin
                        n_sv = 1'b1;
                        n_phase = PH_IDLE;
                        if (!r_known) begin
                            n_off = r_shift;
                            n_known = 1'b1;
                            n_wgt = '0;
                        end else if (r_cal == '0) begin
                            n_wgt = '0;
                        end else begin
                            n_div_w = 1'b1;
                        end
                    end
                end else begin
                    n_bc = r_bc + 1'b1;
                    n_pt = '0;
                end
            end
            PH_RECOVER: begin
                n_sck = 1'b1;
                n_rec = 1'b1;
                if (!r_ta && r_wa && r_wt < WT_W'(REC_TICKS)) n_wt = r_wt + 1'b1;
                n_pt = r_pt + 1'b1;
                if (n_pt >= PT_W'(POWER_DOWN_TICKS)) begin
                    if (r_ta) begin
                        if (r_left != '0) n_left = r_left - 1'b1;
                        n_phase = PH_TARE_GAP;
                        n_pt = '0;
                    end else begin
                        n_phase = PH_IDLE;
                    end
                end
            end
            PH_TARE_WAIT: begin
                if (!i_dout) begin
                    n_phase = PH_READ;
                    n_bc = '0;
                    n_pt = '0;
                    n_shift = '0;
                end else begin
                    if (r_pt <= PT_W'(TO_TICKS)) n_pt = r_pt + 1'b1;
                    if (n_pt > PT_W'(TO_TICKS)) begin
                        n_phase = PH_RECOVER;
                        n_pt = '0;
                    end
                end
            end
            PH_TARE_GAP: begin
                if (r_pt < PT_W'(GAP_TICKS)) n_pt = r_pt + 1'b1;
                if (n_pt >= PT_W'(GAP_TICKS)) begin
                    if (r_left == '0) begin
                        n_known = 1'b1;
                        n_ta = 1'b0;
                        n_done = 1'b1;
                        n_phase = PH_IDLE;
                        n_div_t = 1'b1;
                    end else begin
                        n_phase = PH_TARE_WAIT;
                        n_pt = '0;
                    end
                end
            end
            default: n_phase = PH_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl <= CT_READY;
            r_phase <= PH_IDLE;
            r_gain <= GAIN_RESET; r_cal <= CAL_RESET; r_tsamp <= TARE_DEFAULT;
            r_bc <= '0; r_pt <= '0; r_shift <= '0; r_wt <= '0; r_wa <= 1'b0;
            r_off <= '0; r_known <= 1'b0; r_ta <= 1'b0; r_sum <= '0;
            r_left <= '0; r_total <= '0; r_raw <= '0; r_wgt <= '0;
            r_sck <= 1'b0; r_sv <= 1'b0; r_done <= 1'b0; r_rec <= 1'b0;
            r_dcnt <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_GAIN: r_gain  <= i_cfg_data[GAIN_W-1:0];
                    CFG_CAL:  r_cal   <= i_cfg_data;
                    CFG_TARE: r_tsamp <= i_cfg_data[TS_W-1:0];
                    default: ;
                endcase
            end
            unique case (r_ctrl)
                CT_READY: begin
                    if (w_accept) begin
                        r_phase <= n_phase; r_bc <= n_bc; r_pt <= n_pt;
                        r_shift <= n_shift; r_wt <= n_wt; r_wa <= n_wa;
                        r_off <= n_off; r_known <= n_known; r_ta <= n_ta;
                        r_sum <= n_sum; r_left <= n_left; r_total <= n_total;
                        r_raw <= n_raw; r_wgt <= n_wgt;
                        r_sck <= n_sck; r_sv <= n_sv; r_done <= n_done; r_rec <= n_rec;
                        r_dcnt <= '0;
                        r_rem <= '0;
                        if (n_div_w) begin
                            r_num   <= {w_mag, 16'b0};
                            r_den   <= r_cal;
                            r_dtare <= 1'b0;
                            r_dneg  <= 1'b0;
                            r_ctrl  <= CT_DIV;
                        end else if (n_div_t) begin
                            r_num   <= {{(NUM_W-SUM_W){1'b0}}, w_summag};
                            r_den   <= {{(CAL_W-TS_W){1'b0}}, r_total};
                            r_dtare <= 1'b1;
                            r_dneg  <= r_sum[SUM_W-1];
                            r_ctrl  <= CT_DIV;
                        end else begin
                            r_ctrl  <= CT_OUT;
                        end
                    end
                end
                CT_DIV: begin
                    r_rem  <= w_ge ? CAL_W'(w_trial - {1'b0, r_den}) : w_trial[CAL_W-1:0];
                    r_num  <= w_qnext;
                    r_dcnt <= r_dcnt + 1'b1;
                    if (r_dcnt == DCNT_W'(NUM_W - 1)) begin
                        if (r_dtare) begin
                            r_off <= w_tq[RAW_W-1:0];
                        end else if (w_qnext[NUM_W-1:WGT_W] != '0) begin
                            r_wgt <= '1;
                        end else begin
                            r_wgt <= w_qnext[WGT_W-1:0];
                        end
                        r_ctrl <= CT_OUT;
                    end
                end
                CT_OUT: begin
                    if (!i_stall) r_ctrl <= CT_READY;
                end
                default: r_ctrl <= CT_READY;
            endcase
        end
    end
endmodule

/* bench/load_cell_adc_reader_tb.sv */
// Testbench for the load-cell converter reader: tick stimulus, reference prediction, checks.
`timescale 1ns / 1ps
module load_cell_adc_reader_tb;
    import lcar_pkg::*;

    localparam int CYCLE_LIMIT = 4_000_000;
    localparam int SETTLE      = 60;

    typedef struct packed {
        logic        sck;
        logic        sample_valid;
        logic [23:0] raw;
        logic [31:0] weight;
        logic        tare_busy;
        logic        tare_done;
        logic        recovering;
    } t_reading;

    logic i_clk, i_rst_n, i_valid, o_stall, i_command, i_dout, o_valid, i_stall;
    logic o_sck, o_sample_valid, o_tare_busy, o_tare_done, o_recovering;
    logic signed [RAW_W-1:0] o_raw_value;
    logic [WGT_W-1:0] o_weight;
    logic i_cfg_we;
    logic [CIDX_W-1:0] i_cfg_idx;
    logic [CAL_W-1:0] i_cfg_data;

    load_cell_adc_reader uut (.*);

    // predictor copy of the block state and registers
    t_phase      ph;
    int unsigned bits, ptimer, wtimer, left, total;
    bit          wait_on, offset_set, taring;
    int          offset, last_raw;
    longint      tare_acc;
    logic [23:0] word;
    logic [31:0] last_weight;
    int unsigned gain_reg, cal_reg, tare_reg;

    t_reading expected_q[$];
    int errors, ticks_sent, reads_done, tares_done, cfg_writes;
    int cycles, hold_left;
    bit hold_req, fast, offering;

    initial begin
        i_clk = 0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("load_cell_adc_reader_tb: errors");
            $finish;
        end
    end

    // receiver: random stalls, bursts, and a long hold-off on request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else if (hold_req) begin
            hold_req  = 0;
            hold_left = 300;
            i_stall <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else if (fast) begin
            i_stall <= 1'b0;
        end else begin
            int r;
            r = $urandom_range(0, 19);
            if (r == 19) hold_left = $urandom_range(5, 30);
            i_stall <= (r >= 14);
        end
    end

    // compare each result taken by the receiver with the oldest expectation
    always @(negedge i_clk) begin
        t_reading e, g;
        logic [31:0] ev[7], gv[7];
        string nm[7];
        if (i_rst_n && o_valid && !i_stall) begin
            g = '{o_sck, o_sample_valid, o_raw_value, o_weight, o_tare_busy, o_tare_done,
                  o_recovering};
            if (expected_q.size() == 0) begin
                errors++;
                $display("%0t unexpected result %h", $time, g);
            end else begin
                e = expected_q.pop_front();
                nm = '{"sck", "sample_valid", "raw_value", "weight", "tare_busy",
                       "tare_done", "recovering"};
                ev = '{e.sck, e.sample_valid, e.raw, e.weight, e.tare_busy, e.tare_done,
                       e.recovering};
                gv = '{g.sck, g.sample_valid, g.raw, g.weight, g.tare_busy, g.tare_done,
                       g.recovering};
                for (int i = 0; i < 7; i++) begin
                    if (ev[i] !== gv[i]) begin
                        errors++;
                        if (errors <= 40)
                            $display("%0t %s expected %0h actual %0h", $time, nm[i],
                                     ev[i], gv[i]);
                    end
                end
            end
        end
    end

    function automatic void tare_counted();
        if (left != 0) left--;
        ph = PH_TARE_GAP;
        ptimer = 0;
    endfunction

    function automatic void start_read();
        ph = PH_READ;
        bits = 0;
        ptimer = 0;
        word = '0;
    endfunction

    function automatic t_reading weigh_tick(bit cmd, bit d);
        t_reading r;
        int unsigned pulses;
        longint mag, q;
        r = '0;
        case (ph)
            PH_IDLE: begin
                if (cmd) begin
                    total = (tare_reg != 0) ? tare_reg : 10;
                    left = total;
                    tare_acc = 0;
                    taring = 1;
                    ph = PH_TARE_WAIT;
                    ptimer = 0;
                end else if (d) begin
                    if (!wait_on) begin
                        wait_on = 1;
                        wtimer = 0;
                    end else begin
                        if (wtimer < REC_TICKS) wtimer++;
                        if (wtimer >= REC_TICKS) begin
                            ph = PH_RECOVER;
                            ptimer = 0;
                            wtimer = 0;
                        end
                    end
                end else begin
                    wait_on = 0;
                    wtimer = 0;
                    start_read();
                end
            end
            PH_READ: begin
                if (ptimer == 0) begin
                    r.sck = 1;
                    if (bits < 24) word = {word[22:0], d};
                    ptimer = 1;
                end else begin
                    pulses = (gain_reg < 24) ? 24 : gain_reg;
                    if (bits + 1 >= pulses) begin
                        last_raw = int'(signed'(word));
                        if (taring) begin
                            tare_acc += last_raw;
                            tare_counted();
                        end else begin
                            r.sample_valid = 1;
                            ph = PH_IDLE;
                            if (!offset_set) begin
                                offset = last_raw;
                                offset_set = 1;
                                last_weight = 0;
                            end else begin
                                mag = longint'(last_raw) - longint'(offset);
                                if (mag < 0) mag = -mag;
                                if (cal_reg == 0) begin
                                    last_weight = 0;
                                end else begin
                                    q = (mag << 16) / longint'(cal_reg);
                                    last_weight = (q > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
                                end
                            end
                        end
                    end else begin
                        bits++;
                        ptimer = 0;
                    end
                end
            end
            PH_RECOVER: begin
                r.sck = 1;
                r.recovering = 1;
                if (!taring && wait_on && wtimer < REC_TICKS) wtimer++;
                ptimer++;
                if (ptimer >= POWER_DOWN_TICKS) begin
                    if (taring) tare_counted();
                    else ph = PH_IDLE;
                end
            end
            PH_TARE_WAIT: begin
                if (!d) begin
                    start_read();
                end else begin
                    if (ptimer <= TO_TICKS) ptimer++;
                    if (ptimer > TO_TICKS) begin
                        ph = PH_RECOVER;
                        ptimer = 0;
                    end
                end
            end
            default: begin
                if (ptimer < GAP_TICKS) ptimer++;
                if (ptimer >= GAP_TICKS) begin
                    if (left == 0) begin
                        offset = int'(tare_acc / longint'((total != 0) ? total : 1));
                        offset_set = 1;
                        taring = 0;
                        r.tare_done = 1;
                        ph = PH_IDLE;
                    end else begin
                        ph = PH_TARE_WAIT;
                        ptimer = 0;
                    end
                end
            end
        endcase
        r.raw = last_raw[23:0];
        r.weight = last_weight;
        r.tare_busy = taring;
        return r;
    endfunction

    // offer one tick; returns at the rising edge that takes it, after any idle gap
    task automatic send_tick(bit cmd, bit d);
        int r, gap;
        i_valid <= 1'b1;
        i_command <= cmd;
        i_dout <= d;
        offering = 1;
        forever begin
            @(negedge i_clk);
            if (!o_stall) break;
        end
        expected_q.push_back(weigh_tick(cmd, d));
        ticks_sent++;
        @(posedge i_clk);
        r = $urandom_range(0, 19);
        gap = fast ? 0 : (r < 12) ? 0 : (r < 19) ? $urandom_range(1, 3) : $urandom_range(10, 40);
        if (gap > 0) begin
            i_valid <= 1'b0;
            offering = 0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        while (ph != PH_IDLE) send_tick(1'b0, 1'b1);
        if (offering) begin
            i_valid <= 1'b0;
            offering = 0;
        end
        wait (expected_q.size() == 0);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CIDX_W-1:0] idx, int unsigned value);
        drain();
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= value[CAL_W-1:0];
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_GAIN: gain_reg = value & 5'h1F;
            CFG_CAL:  cal_reg = value & 24'hFF_FFFF;
            default:  tare_reg = value & 8'hFF;
        endcase
        cfg_writes++;
    endtask

    // one complete conversion read from idle, word MSB first
    task automatic read_word(logic [23:0] w);
        int unsigned pulses;
        pulses = (gain_reg < 24) ? 24 : gain_reg;
        send_tick(1'b0, 1'b0);
        for (int p = 0; p < pulses; p++) begin
            send_tick(1'b0, (p < 24) ? w[23-p] : 1'($urandom));
            send_tick(1'($urandom), 1'($urandom));
        end
        reads_done++;
    endtask

    function automatic logic [23:0] pick_word();
        case ($urandom_range(0, 7))
            0: return 24'h000000;
            1: return 24'hFFFFFF;
            2: return 24'h800000;
            3: return 24'h7FFFFF;
            default: return 24'($urandom);
        endcase
    endfunction

    task automatic test_first_sample();
        read_word(24'h123456);
        read_word(24'h123456);
        read_word(24'h100000);
    endtask

    task automatic test_extremes();
        read_word(24'h7FFFFF);
        read_word(24'h800000);
        read_word(24'hFFFFFF);
        read_word(24'h000000);
    endtask

    task automatic test_gain_settings();
        int unsigned g[5] = '{26, 27, 0, 31, 25};
        foreach (g[i]) begin
            write_reg(CFG_GAIN, g[i]);
            read_word(pick_word());
        end
    endtask

    task automatic test_calibration_edges();
        write_reg(CFG_CAL, 0);
        read_word(24'h7FFFFF);
        write_reg(CFG_CAL, 1);
        read_word(24'h800000);
        write_reg(CFG_CAL, 24'hFFFFFF);
        read_word(24'h7FFFFF);
        write_reg(CFG_CAL, 256);
        read_word(24'h000100);
    endtask

    task automatic test_not_ready();
        repeat (40) send_tick(1'b0, 1'b1);
        read_word(24'h0F0F0F);
        repeat (5) send_tick(1'b0, 1'b1);
    endtask

    // tare with a few not-ready ticks before each read and the full gap after it
    task automatic run_tare(int unsigned n, logic [23:0] base);
        write_reg(CFG_TARE, n);
        fast = 1;
        send_tick(1'b1, 1'b1);
        for (int k = 0; k < n; k++) begin
            repeat ($urandom_range(1, 6)) send_tick(1'b0, 1'b1);
            read_word(base - 24'(k));
            reads_done--;
            repeat (GAP_TICKS) send_tick(1'($urandom), 1'($urandom));
        end
        fast = 0;
        tares_done++;
    endtask

    task automatic test_tare();
        run_tare(1, 24'h000400);
        read_word(24'h000800);
        run_tare(2, 24'hFFFFFF);
        read_word(24'h000000);
        write_reg(CFG_TARE, 0);
        write_reg(CFG_TARE, 255);
        write_reg(CFG_TARE, 10);
    endtask

    task automatic test_backpressure();
        hold_req = 1;
        repeat (60) send_tick(1'b0, 1'b1);
        read_word(pick_word());
        // stop offering and wait for every result before the next read
        drain();
        read_word(pick_word());
    endtask

    task automatic test_random();
        int unsigned target;
        int r;
        target = ticks_sent + 1000;
        while (ticks_sent < target) begin
            r = $urandom_range(0, 99);
            if (r < 6) begin
                write_reg(r < 3 ? CFG_GAIN : CFG_CAL,
                          r == 0 ? $urandom_range(25, 27) : r < 3 ? $urandom_range(0, 31)
                          : r == 3 ? $urandom_range(0, 3) : $urandom_range(0, 24'hFFFFFF));
            end else if (r < 20) begin
                repeat ($urandom_range(1, 8)) send_tick(1'b0, 1'($urandom));
            end else begin
                if (r < 24) fast = 1;
                read_word(pick_word());
                fast = 0;
            end
        end
        write_reg(CFG_GAIN, 25);
        write_reg(CFG_CAL, 110080);
    endtask

    initial begin
        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_command <= 1'b0;
        i_dout <= 1'b1;
        i_cfg_we <= 1'b0;
        i_cfg_idx <= CFG_GAIN;
        i_cfg_data <= '0;
        ph = PH_IDLE;
        gain_reg = 25;
        cal_reg = 110080;
        tare_reg = 10;
        last_weight = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_first_sample();
        test_extremes();
        test_gain_settings();
        test_calibration_edges();
        test_not_ready();
        test_tare();
        test_backpressure();
        test_random();

        drain();
        $display("ticks %0d, conversion reads %0d, tares %0d, register writes %0d",
                 ticks_sent, reads_done, tares_done, cfg_writes);
        $display("covered gain and calibration extremes, first-sample offset, back-pressure");
        if (errors == 0 && expected_q.size() == 0) begin
            $display("load_cell_adc_reader_tb: clean");
        end else begin
            $display("load_cell_adc_reader_tb: errors");
        end
        $finish;
    end
endmodule
